FILE: sv/mtidc_pkg.sv
`default_nettype none

package mtidc_pkg;

	localparam int SqrtSteps = 25;
	localparam int DivSteps = 26;
	localparam logic [31:0] CanonNan = 32'h7FC0_0000;

	// Class of the square root; a zero root yields an infinite reciprocal.
	typedef enum logic [1:0] {
		CLS_NUM,
		CLS_ZERO,
		CLS_INF,
		CLS_NAN
	} xcls_t;

	typedef struct packed {
		logic valid;
		logic last;
	} side_t;

	typedef struct packed {
		logic        valid;
		logic        last;
		logic [31:0] m;
		xcls_t       cls;
		logic        sgn;
		logic [7:0]  es;
		logic [25:0] rad;
		logic [25:0] rem;
		logic [24:0] root;
	} sq_t;

	typedef struct packed {
		logic        valid;
		logic        last;
		logic [31:0] m;
		xcls_t       cls;
		logic        sgn;
		logic [7:0]  es;
		logic [23:0] dvs;
		logic [24:0] rem;
		logic [25:0] q;
	} dv_t;

	typedef struct packed {
		logic [23:0]        sig;
		logic signed [9:0]  e;
	} nsig_t;

	typedef struct packed {
		logic               nan;
		logic               inf;
		logic               zero;
		logic               sgn;
		logic signed [10:0] e;
		logic [23:0]        sa;
		logic [23:0]        sb;
	} fm_a_t;

	typedef struct packed {
		logic               nan;
		logic               inf;
		logic               zero;
		logic               sgn;
		logic signed [10:0] e;
		logic [47:0]        p;
	} fm_b_t;

	typedef struct packed {
		logic        nan;
		logic        inf;
		logic        zero;
		logic        sgn;
		logic        ovf;
		logic [7:0]  ef;
		logic [47:0] q;
		logic        sticky;
	} fm_c_t;

	function automatic logic [4:0] lead_zeros(logic [23:0] v);
		logic [4:0] n;
		n = 5'd24;
		for (int i = 0; i < 24; i++) begin
			if (v[i]) n = 5'(23 - i);
		end
		return n;
	endfunction

	// Significand with its leading one at bit 23 and the matching biased exponent.
	function automatic nsig_t norm_sig(logic [7:0] ex, logic [22:0] man);
		nsig_t r;
		logic [4:0] n;
		n = lead_zeros({1'b0, man});
		if (ex != 8'd0) begin
			r.sig = {1'b1, man};
			r.e = $signed({2'b00, ex});
		end else begin
			r.sig = {1'b0, man} << n;
			r.e = 10'sd1 - $signed({5'd0, n});
		end
		return r;
	endfunction

	function automatic sq_t sqrt_unpack(logic valid, logic last, logic [31:0] x,
			logic [31:0] m);
		sq_t r;
		nsig_t ns;
		logic signed [9:0] e;
		logic signed [9:0] ee;
		logic signed [9:0] es;
		ns = norm_sig(x[30:23], x[22:0]);
		e = ns.e - 10'sd150;
		if (e[0]) begin
			r.rad = {1'b0, ns.sig, 1'b0};
			ee = e - 10'sd1;
		end else begin
			r.rad = {ns.sig, 2'b00};
			ee = e - 10'sd2;
		end
		es = (ee >>> 1) + 10'sd139;
		r.valid = valid;
		r.last = last;
		r.m = m;
		r.sgn = x[31];
		r.es = es[7:0];
		r.rem = '0;
		r.root = '0;
		if (x[30:23] == 8'hFF && x[22:0] != 23'd0) r.cls = CLS_NAN;
		else if (x[30:0] == 31'd0) r.cls = CLS_ZERO;
		else if (x[31]) r.cls = CLS_NAN;
		else if (x[30:23] == 8'hFF) r.cls = CLS_INF;
		else r.cls = CLS_NUM;
		return r;
	endfunction

	// One restoring step of the integer root: two radicand bits in, one root bit out.
	function automatic sq_t sqrt_step(sq_t a);
		sq_t r;
		logic [26:0] rsh;
		logic [26:0] t;
		logic [26:0] d;
		r = a;
		rsh = {a.rem[24:0], a.rad[25:24]};
		t = {a.root, 2'b01};
		d = rsh - t;
		if (rsh >= t) begin
			r.rem = d[25:0];
			r.root = {a.root[23:0], 1'b1};
		end else begin
			r.rem = rsh[25:0];
			r.root = {a.root[23:0], 1'b0};
		end
		r.rad = {a.rad[23:0], 2'b00};
		return r;
	endfunction

	function automatic dv_t sqrt_finish(sq_t a);
		dv_t r;
		logic inc;
		logic [24:0] sum;
		inc = a.root[0] & ((a.rem != 26'd0) | a.root[1]);
		sum = {1'b0, a.root[24:1]} + {24'd0, inc};
		r.valid = a.valid;
		r.last = a.last;
		r.m = a.m;
		r.cls = a.cls;
		r.sgn = a.sgn;
		if (sum[24]) begin
			r.dvs = 24'h80_0000;
			r.es = a.es + 8'd1;
		end else begin
			r.dvs = sum[23:0];
			r.es = a.es;
		end
		// The dividend is 1.0 in the divisor's scale.
		r.rem = 25'h080_0000;
		r.q = '0;
		return r;
	endfunction

	function automatic dv_t div_step(dv_t a);
		dv_t r;
		logic [24:0] d;
		logic qb;
		r = a;
		qb = (a.rem >= {1'b0, a.dvs});
		d = qb ? (a.rem - {1'b0, a.dvs}) : a.rem;
		r.rem = {d[23:0], 1'b0};
		r.q = {a.q[24:0], qb};
		return r;
	endfunction

	function automatic logic [31:0] recip_pack(dv_t a);
		logic [23:0] sig;
		logic g;
		logic st;
		logic inc;
		logic [7:0] ey;
		logic [30:0] fld;
		logic [31:0] y;
		if (a.q[25]) begin
			sig = a.q[25:2];
			g = a.q[1];
			st = a.q[0] | (a.rem != 25'd0);
			ey = 8'd254 - a.es;
		end else begin
			sig = a.q[24:1];
			g = a.q[0];
			st = (a.rem != 25'd0);
			ey = 8'd253 - a.es;
		end
		inc = g & (st | sig[0]);
		fld = {ey, sig[22:0]} + {30'd0, inc};
		case (a.cls)
			CLS_NUM: y = {1'b0, fld};
			CLS_ZERO: y = {a.sgn, 8'hFF, 23'd0};
			CLS_INF: y = 32'd0;
			default: y = CanonNan;
		endcase
		return y;
	endfunction

	function automatic fm_a_t fmul_prep(logic [31:0] a, logic [31:0] b);
		fm_a_t r;
		nsig_t na;
		nsig_t nb;
		logic anan;
		logic bnan;
		logic ainf;
		logic binf;
		logic azero;
		logic bzero;
		na = norm_sig(a[30:23], a[22:0]);
		nb = norm_sig(b[30:23], b[22:0]);
		anan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		bnan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		ainf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		binf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		azero = (a[30:0] == 31'd0);
		bzero = (b[30:0] == 31'd0);
		r.nan = anan | bnan | (ainf & bzero) | (azero & binf);
		r.inf = ainf | binf;
		r.zero = azero | bzero;
		r.sgn = a[31] ^ b[31];
		r.e = 11'(na.e) + 11'(nb.e) - 11'sd126;
		r.sa = na.sig;
		r.sb = nb.sig;
		return r;
	endfunction

	// Brings the product to a leading one at bit 47, or shifts it into the subnormal range.
	function automatic fm_c_t fmul_norm(fm_b_t a);
		fm_c_t r;
		logic [47:0] p;
		logic signed [10:0] e;
		logic signed [10:0] shw;
		logic [7:0] sh;
		logic [47:0] mask;
		p = a.p;
		e = a.e;
		if (!p[47]) begin
			p = {p[46:0], 1'b0};
			e = e - 11'sd1;
		end
		r.nan = a.nan;
		r.inf = a.inf;
		r.zero = a.zero;
		r.sgn = a.sgn;
		r.ovf = (e >= 11'sd255);
		r.sticky = 1'b0;
		shw = 11'sd1 - e;
		sh = shw[7:0];
		mask = ~({48{1'b1}} << sh);
		if (e <= 11'sd0) begin
			r.ef = 8'd0;
			if (sh >= 8'd48) begin
				r.q = '0;
				r.sticky = |p;
			end else begin
				r.q = p >> sh;
				r.sticky = |(p & mask);
			end
		end else begin
			r.ef = e[7:0];
			r.q = p;
		end
		return r;
	endfunction

	function automatic logic [31:0] fmul_pack(fm_c_t a);
		logic [30:0] fld;
		logic g;
		logic st;
		logic inc;
		logic [31:0] z;
		fld = {a.ef, a.q[46:24]};
		g = a.q[23];
		st = a.sticky | (|a.q[22:0]);
		inc = g & (st | a.q[24]);
		if (a.nan) z = CanonNan;
		else if (a.inf || a.ovf) z = {a.sgn, 8'hFF, 23'd0};
		else if (a.zero) z = {a.sgn, 31'd0};
		else z = {a.sgn, fld + {30'd0, inc}};
		return z;
	endfunction

endpackage

`default_nettype wire

FILE: sv/mass_times_inverse_distance_cubed.sv
// The pipeline takes one item per cycle while the skid entry is empty; the root
// and the reciprocal resolve one bit per stage over 25 and 26 stages, and each of the
// two multiply levels takes four stages.
// A two-entry output buffer keeps input transfers going while one result waits.
// Reset clears every pipeline valid bit and the output buffer, not the multiply payload.
`default_nettype none

module mass_times_inverse_distance_cubed
	import mtidc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] dist_sq_bits,
	input  wire logic [31:0] mass_bits,
	input  wire logic        last_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      result_bits,
	output logic             last_out
);

	typedef struct packed {
		logic        valid;
		logic        last;
		logic [31:0] bits;
	} res_t;

	sq_t   sq_s [0:SqrtSteps];
	dv_t   dv_s [0:DivSteps];
	side_t sd_s [0:8];

	logic [31:0] y_s0;
	logic [31:0] m_s0;
	fm_a_t fa_yy_s1;
	fm_a_t fa_my_s1;
	fm_b_t fb_yy_s2;
	fm_b_t fb_my_s2;
	fm_c_t fc_yy_s3;
	fm_c_t fc_my_s3;
	logic [31:0] y2_s4;
	logic [31:0] my_s4;
	fm_a_t fa_s5;
	fm_b_t fb_s6;
	fm_c_t fc_s7;
	logic [31:0] z_s8;

	res_t out_q;
	res_t skid_q;
	logic en;
	logic out_free;

	assign en = !skid_q.valid;
	assign in_ready = en;
	assign out_free = !out_q.valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= SqrtSteps; k++) sq_s[k] <= '0;
			for (int k = 0; k <= DivSteps; k++) dv_s[k] <= '0;
			for (int k = 0; k <= 8; k++) sd_s[k] <= '0;
		end else if (en) begin
			sq_s[0] <= sqrt_unpack(in_valid, last_in, dist_sq_bits, mass_bits);
			for (int k = 1; k <= SqrtSteps; k++) sq_s[k] <= sqrt_step(sq_s[k-1]);
			dv_s[0] <= sqrt_finish(sq_s[SqrtSteps]);
			for (int k = 1; k <= DivSteps; k++) dv_s[k] <= div_step(dv_s[k-1]);
			sd_s[0] <= '{valid: dv_s[DivSteps].valid, last: dv_s[DivSteps].last};
			for (int k = 1; k <= 8; k++) sd_s[k] <= sd_s[k-1];
		end
	end

	// Payload of the multiply stages; the valid bits above qualify it.
	always_ff @(posedge clk) begin
		if (en) begin
			y_s0 <= recip_pack(dv_s[DivSteps]);
			m_s0 <= dv_s[DivSteps].m;
			fa_yy_s1 <= fmul_prep(y_s0, y_s0);
			fa_my_s1 <= fmul_prep(m_s0, y_s0);
			fb_yy_s2 <= '{nan: fa_yy_s1.nan, inf: fa_yy_s1.inf, zero: fa_yy_s1.zero,
				sgn: fa_yy_s1.sgn, e: fa_yy_s1.e,
				p: {24'd0, fa_yy_s1.sa} * {24'd0, fa_yy_s1.sb}};
			fb_my_s2 <= '{nan: fa_my_s1.nan, inf: fa_my_s1.inf, zero: fa_my_s1.zero,
				sgn: fa_my_s1.sgn, e: fa_my_s1.e,
				p: {24'd0, fa_my_s1.sa} * {24'd0, fa_my_s1.sb}};
			fc_yy_s3 <= fmul_norm(fb_yy_s2);
			fc_my_s3 <= fmul_norm(fb_my_s2);
			y2_s4 <= fmul_pack(fc_yy_s3);
			my_s4 <= fmul_pack(fc_my_s3);
			fa_s5 <= fmul_prep(my_s4, y2_s4);
			fb_s6 <= '{nan: fa_s5.nan, inf: fa_s5.inf, zero: fa_s5.zero,
				sgn: fa_s5.sgn, e: fa_s5.e,
				p: {24'd0, fa_s5.sa} * {24'd0, fa_s5.sb}};
			fc_s7 <= fmul_norm(fb_s6);
			z_s8 <= fmul_pack(fc_s7);
		end
	end

	// The last pipeline stage empties on every enabled cycle, into the output
	// register when it is free and into the skid entry otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
			skid_q <= '0;
		end else if (skid_q.valid) begin
			if (out_ready) begin
				out_q <= skid_q;
				skid_q.valid <= 1'b0;
			end
		end else if (sd_s[8].valid) begin
			if (out_free) out_q <= '{valid: 1'b1, last: sd_s[8].last, bits: z_s8};
			else skid_q <= '{valid: 1'b1, last: sd_s[8].last, bits: z_s8};
		end else if (out_free) begin
			out_q.valid <= 1'b0;
		end
	end

	assign out_valid = out_q.valid;
	assign result_bits = out_q.bits;
	assign last_out = out_q.last;

	assert property (@(posedge clk) disable iff (!arst_n)
		skid_q.valid |-> out_q.valid)
		else $error("skid entry holds a result while the output register is empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		skid_q.valid && !out_ready |=> skid_q.valid && $stable(skid_q.bits))
		else $error("skid entry lost or changed while the output stalls");

	assert property (@(posedge clk) disable iff (!arst_n)
		en && sd_s[8].valid |=> out_q.valid)
		else $error("a finished result left the pipeline without reaching the output");

	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_q.valid && !$past(out_ready && skid_q.valid))
		else $error("input stalled while the output buffer could drain");

endmodule

`default_nettype wire
